>>> design/keyed_order_table_defines.svh
// Assertion macros of the keyed order table RTL.
// No dependencies; included by the files that carry assertions.
`ifndef KEYED_ORDER_TABLE_DEFINES_SVH
`define KEYED_ORDER_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define KOT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define KOT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/kot_pkg.sv
// Shared types, constants and the key normalization function of the keyed order table.
// No dependencies; used by every module of the block but kot_ram.
package kot_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_BYTES = 8;
    localparam int KEY_W     = 64;
    localparam int FIELD_W   = 16;
    localparam int PAY_W     = 3 * FIELD_W;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Command codes; the fourth code means nothing and is answered as no match.
    localparam logic [1:0] CMD_PUT        = 2'd0;
    localparam logic [1:0] CMD_TAKE       = 2'd1;
    localparam logic [1:0] CMD_REMOVE_ALL = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [KEY_W-1:0]   flight_key;
        logic [FIELD_W-1:0] in_heading;
        logic [FIELD_W-1:0] in_speed;
        logic [FIELD_W-1:0] in_altitude;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] out_heading;
        logic [FIELD_W-1:0] out_speed;
        logic [FIELD_W-1:0] out_altitude;
        logic [CNT_W-1:0]   entry_count;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the accepted command
        logic put;       // append the captured entry if room remains
        logic rd_entry;  // read the entry at the scan index
        logic rd_last;   // read the last entry
        logic check;     // compare the entry read at the scan index
        logic take;      // keep the payload of a matching entry
        logic move;      // write the last entry into the scan slot
        logic next;      // advance the scan index
        logic respond;   // register the result
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match;
        logic at_end;
    } t_dp_stat;

    // Keep the bytes below KEY_BYTES and before the first zero byte.
    function automatic logic [KEY_W-1:0] norm_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        logic             live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (k[8*b +: 8] == 8'h00) begin
                live = 1'b0;
            end
            if (live) begin
                r[8*b +: 8] = k[8*b +: 8];
            end
        end
        return r;
    endfunction

endpackage

>>> design/keyed_order_table.sv
// Top level of the keyed order table: controller and datapath.
// Depends on kot_pkg, kot_ctrl and kot_dp.
//
// Channel    Handshake                    Payload
// command    start / busy (start & !busy) i_item   (kot_pkg::t_cmd_item)
// result     o_result_strobe, one cycle   o_result (kot_pkg::t_result)
//
// A put passes S_PUT and S_DONE after its transfer; an unused command goes straight to
// S_DONE. A take or remove-all passes S_SCAN and S_CHECK per entry checked, S_LAST and
// S_MOVE per entry removed, and ends through S_SCAN at the end and S_DONE (a take that finds
// its entry goes from S_MOVE to S_DONE); the single registered read port sets this pace.
// Reset clears the fill count, the result strobe and the controller only; the memories get no clearing pass.
// The result stays one cycle, the receiver cannot stall, and a new command may be taken then.
module keyed_order_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  kot_pkg::t_cmd_item i_item,
    output kot_pkg::t_result   o_result,
    output logic               o_result_strobe
);

    kot_pkg::t_dp_ctrl ctrl;
    kot_pkg::t_dp_stat stat;
    logic              accept;

    assign accept = start && !busy;

    kot_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (i_item.command),
        .i_stat    (stat),
        .o_ctrl    (ctrl),
        .o_busy    (busy)
    );

    kot_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_ctrl          (ctrl),
        .o_stat          (stat),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

endmodule

>>> design/kot_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/kot_ctrl.sv
// Controller state machine of the keyed order table: sequences put, scan and swap-remove.
// Depends on kot_pkg.
module kot_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_command,
    input  kot_pkg::t_dp_stat  i_stat,
    output kot_pkg::t_dp_ctrl  o_ctrl,
    output logic               o_busy
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PUT   = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_LAST  = 7'b0010000,
        S_MOVE  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic       r_is_take, n_is_take;

    // Next state and datapath commands.
    always_comb begin
        n_state   = r_state;
        n_is_take = r_is_take;
        o_ctrl    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_ctrl.load = 1'b1;
                    n_is_take   = (i_command == kot_pkg::CMD_TAKE);
                    priority if (i_command == kot_pkg::CMD_PUT) begin
                        n_state = S_PUT;
                    end else if (i_command == kot_pkg::CMD_TAKE ||
                                 i_command == kot_pkg::CMD_REMOVE_ALL) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PUT: begin
                o_ctrl.put = 1'b1;
                n_state    = S_DONE;
            end
            S_SCAN: begin
                if (i_stat.at_end) begin
                    n_state = S_DONE;
                end else begin
                    o_ctrl.rd_entry = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                o_ctrl.check = 1'b1;
                o_ctrl.take  = r_is_take;
                if (i_stat.match) begin
                    n_state = S_LAST;
                end else begin
                    o_ctrl.next = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_LAST: begin
                o_ctrl.rd_last = 1'b1;
                n_state        = S_MOVE;
            end
            S_MOVE: begin
                // A take ends here; remove-all checks the same slot again.
                o_ctrl.move = 1'b1;
                n_state     = r_is_take ? S_DONE : S_SCAN;
            end
            S_DONE: begin
                o_ctrl.respond = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_take <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_take <= n_is_take;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> design/kot_dp.sv
// Datapath of the keyed order table: key and payload memories, fill count, scan index, result.
// Depends on kot_pkg, kot_ram and keyed_order_table_defines.svh.
`include "keyed_order_table_defines.svh"

module kot_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kot_pkg::t_cmd_item i_item,
    input  kot_pkg::t_dp_ctrl  i_ctrl,
    output kot_pkg::t_dp_stat  o_stat,
    output kot_pkg::t_result   o_result,
    output logic               o_result_strobe
);

    logic [kot_pkg::KEY_W-1:0]   r_key;
    logic [kot_pkg::PAY_W-1:0]   r_put_pay;
    logic [kot_pkg::PAY_W-1:0]   r_pay;
    logic [1:0]                  r_status;
    logic [kot_pkg::CNT_W-1:0]   r_idx;
    logic [kot_pkg::CNT_W-1:0]   r_count;
    kot_pkg::t_result            r_res;
    logic                        r_res_valid;

    logic                        full;
    logic [kot_pkg::IDX_W-1:0]   last_idx;
    logic                        we;
    logic [kot_pkg::IDX_W-1:0]   waddr;
    logic [kot_pkg::KEY_W-1:0]   key_wdata;
    logic [kot_pkg::PAY_W-1:0]   pay_wdata;
    logic                        re;
    logic [kot_pkg::IDX_W-1:0]   raddr;
    logic [kot_pkg::KEY_W-1:0]   key_rdata;
    logic [kot_pkg::PAY_W-1:0]   pay_rdata;

    assign full     = (r_count == kot_pkg::CNT_W'(kot_pkg::CAPACITY));
    assign last_idx = kot_pkg::IDX_W'(r_count - kot_pkg::CNT_W'(1));

    // Memory port selection: a put appends at the fill count, a move copies the
    // last entry (just read) into the scan slot.
    assign we        = (i_ctrl.put && !full) || i_ctrl.move;
    assign waddr     = i_ctrl.move ? r_idx[kot_pkg::IDX_W-1:0]
                                   : r_count[kot_pkg::IDX_W-1:0];
    assign key_wdata = i_ctrl.move ? key_rdata : r_key;
    assign pay_wdata = i_ctrl.move ? pay_rdata : r_put_pay;
    assign re        = i_ctrl.rd_entry || i_ctrl.rd_last;
    assign raddr     = i_ctrl.rd_last ? last_idx : r_idx[kot_pkg::IDX_W-1:0];

    kot_ram #(
        .WIDTH (kot_pkg::KEY_W),
        .DEPTH (kot_pkg::CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (key_rdata)
    );

    kot_ram #(
        .WIDTH (kot_pkg::PAY_W),
        .DEPTH (kot_pkg::CAPACITY)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (pay_wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (pay_rdata)
    );

    // Status back to the controller.
    assign o_stat.match  = (key_rdata == r_key);
    assign o_stat.at_end = (r_idx >= r_count);

    // Fill count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_ctrl.respond;
            if (i_ctrl.put && !full) begin
                r_count <= r_count + kot_pkg::CNT_W'(1);
            end else if (i_ctrl.move) begin
                r_count <= r_count - kot_pkg::CNT_W'(1);
            end
        end
    end

    // Command capture, scan index, status, payload of the transfer and the registered result.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_key     <= kot_pkg::norm_key(i_item.flight_key);
            r_put_pay <= {i_item.in_heading, i_item.in_speed, i_item.in_altitude};
            r_pay     <= '0;
            r_status  <= kot_pkg::ST_NOMATCH;
            r_idx     <= '0;
        end else begin
            if (i_ctrl.put) begin
                r_status <= full ? kot_pkg::ST_FULL : kot_pkg::ST_DONE;
            end
            if (i_ctrl.check && o_stat.match) begin
                r_status <= kot_pkg::ST_DONE;
                if (i_ctrl.take) begin
                    r_pay <= pay_rdata;
                end
            end
            if (i_ctrl.next) begin
                r_idx <= r_idx + kot_pkg::CNT_W'(1);
            end
        end
        if (i_ctrl.respond) begin
            r_res.status       <= r_status;
            r_res.out_heading  <= r_pay[3*kot_pkg::FIELD_W-1 -: kot_pkg::FIELD_W];
            r_res.out_speed    <= r_pay[2*kot_pkg::FIELD_W-1 -: kot_pkg::FIELD_W];
            r_res.out_altitude <= r_pay[kot_pkg::FIELD_W-1:0];
            r_res.entry_count  <= r_count;
        end
    end

    assign o_result        = r_res;
    assign o_result_strobe = r_res_valid;

    // The fill count never passes the capacity.
    `KOT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= kot_pkg::CNT_W'(kot_pkg::CAPACITY), "fill count above capacity")
    // A move only happens on a table that holds an entry inside the scan range.
    `KOT_ASSERT_NOW(a_move_in_range, i_clk, i_rst_n, i_ctrl.move,
        r_count != '0 && r_idx < r_count, "move outside the held entries")
    // A put with room grows the table by exactly one entry.
    `KOT_ASSERT_NEXT(a_put_grows, i_clk, i_rst_n, i_ctrl.put && !full,
        r_count == $past(r_count) + kot_pkg::CNT_W'(1), "put did not add one entry")

endmodule

>>> sim/keyed_order_table_test.sv
// Self-checking testbench for keyed_order_table: put, take and remove-all commands
// against a behavioral copy of the table, with directed rows first and random traffic after.
// Depends on kot_pkg and the keyed_order_table RTL.
module keyed_order_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    // The fourth command code has no meaning and is answered as no match.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int POOL_SIZE  = 8;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 275;
    localparam int SETTLE     = 4 * kot_pkg::CAPACITY + 16;
    localparam int LIMIT      = 2_000_000;
    localparam int IDLE_PCT [PHASES] = '{0, 62, 22, 0, 62, 22};

    typedef struct packed {
        kot_pkg::t_cmd_item it;
        logic               typed;
        kot_pkg::t_result   want;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    kot_pkg::t_cmd_item i_item;
    kot_pkg::t_result   o_result;
    logic               o_result_strobe;

    // Shadow copy of the table contents.
    logic [kot_pkg::KEY_W-1:0] held_key [kot_pkg::CAPACITY];
    logic [kot_pkg::PAY_W-1:0] held_pay [kot_pkg::CAPACITY];
    int                        held_count;

    // Keys that random traffic draws from, so that matches are common.
    logic [kot_pkg::KEY_W-1:0] pool_base [POOL_SIZE];
    int                        pool_len [POOL_SIZE];

    kot_pkg::t_result pending_results [$];
    t_plan_row        plan [$];
    int               failures;
    int               cycle_count = 0;

    keyed_order_table uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

    always #5ns i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("keyed_order_table_test NOT OK");
            $finish;
        end
    end

    // A key keeps its bytes up to the first zero byte and below KEY_BYTES.
    function automatic logic [kot_pkg::KEY_W-1:0] key_canon(
        input logic [kot_pkg::KEY_W-1:0] raw);
        logic [kot_pkg::KEY_W-1:0] k;
        logic                      ended;
        k     = '0;
        ended = 1'b0;
        for (int b = 0; b < kot_pkg::KEY_BYTES; b++) begin
            if (raw[8*b +: 8] == 8'h00) begin
                ended = 1'b1;
            end
            if (!ended) begin
                k[8*b +: 8] = raw[8*b +: 8];
            end
        end
        return k;
    endfunction

    // Fill the hole at slot idx with the last entry.
    function automatic void drop_entry(input int idx);
        held_key[idx] = held_key[held_count-1];
        held_pay[idx] = held_pay[held_count-1];
        held_count--;
    endfunction

    // Apply one command to the shadow table and return the result it should give.
    function automatic kot_pkg::t_result table_apply(input kot_pkg::t_cmd_item it);
        kot_pkg::t_result          r;
        logic [kot_pkg::KEY_W-1:0] k;
        logic                      found;
        int                        i;
        r        = '0;
        r.status = kot_pkg::ST_NOMATCH;
        k        = key_canon(it.flight_key);
        found    = 1'b0;
        case (it.command)
            kot_pkg::CMD_PUT: begin
                if (held_count < kot_pkg::CAPACITY) begin
                    held_key[held_count] = k;
                    held_pay[held_count] = {it.in_heading, it.in_speed, it.in_altitude};
                    held_count++;
                    r.status = kot_pkg::ST_DONE;
                end else begin
                    r.status = kot_pkg::ST_FULL;
                end
            end
            kot_pkg::CMD_TAKE: begin
                for (i = 0; i < held_count && !found; i++) begin
                    if (held_key[i] == k) begin
                        {r.out_heading, r.out_speed, r.out_altitude} = held_pay[i];
                        drop_entry(i);
                        r.status = kot_pkg::ST_DONE;
                        found    = 1'b1;
                    end
                end
            end
            kot_pkg::CMD_REMOVE_ALL: begin
                // The slot is checked again after a swap, since the moved entry may match.
                i = 0;
                while (i < held_count) begin
                    if (held_key[i] == k) begin
                        drop_entry(i);
                        r.status = kot_pkg::ST_DONE;
                    end else begin
                        i++;
                    end
                end
            end
            default: begin
            end
        endcase
        r.entry_count = kot_pkg::CNT_W'(held_count);
        return r;
    endfunction

    function automatic t_plan_row row(input logic [1:0] cmd,
                                      input logic [kot_pkg::KEY_W-1:0] key,
                                      input logic [15:0] h, input logic [15:0] s,
                                      input logic [15:0] a, input logic typed,
                                      input logic [1:0] st, input logic [15:0] oh,
                                      input logic [15:0] os, input logic [15:0] oa,
                                      input int cnt);
        t_plan_row p;
        p.it    = '{command: cmd, flight_key: key, in_heading: h, in_speed: s,
                    in_altitude: a};
        p.typed = typed;
        p.want  = '{status: st, out_heading: oh, out_speed: os, out_altitude: oa,
                    entry_count: kot_pkg::CNT_W'(cnt)};
        return p;
    endfunction

    // Draw a fresh set of keys, from empty up to the full key length.
    task automatic refresh_pool();
        for (int p = 0; p < POOL_SIZE; p++) begin
            pool_len[p]  = $urandom_range(0, kot_pkg::KEY_BYTES);
            pool_base[p] = '0;
            for (int b = 0; b < pool_len[p]; b++) begin
                pool_base[p][8*b +: 8] = 8'($urandom_range(1, 255));
            end
        end
    endtask

    // A pool key, with random bytes past its terminating zero that must not matter.
    function automatic logic [kot_pkg::KEY_W-1:0] pool_variant(input int p);
        logic [kot_pkg::KEY_W-1:0] k;
        k = pool_base[p];
        for (int b = pool_len[p] + 1; b < kot_pkg::KEY_BYTES; b++) begin
            if ($urandom_range(0, 1) == 1) begin
                k[8*b +: 8] = 8'($urandom);
            end
        end
        return k;
    endfunction

    // Offer one command and hold it until its transfer; then predict its result.
    task automatic issue(input kot_pkg::t_cmd_item it, input logic typed,
                         input kot_pkg::t_result want);
        kot_pkg::t_result predicted;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predicted = table_apply(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending until every outstanding result has arrived.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Random traffic with occasional bursts of puts that run the table full.
    task automatic run_random(input int n_items, input int idle_pct);
        kot_pkg::t_cmd_item it;
        int                 fill_left;
        int                 pick;
        fill_left = 0;
        repeat (n_items) begin
            if (fill_left == 0 && $urandom_range(0, 119) == 0) begin
                fill_left = kot_pkg::CAPACITY - held_count + 3;
            end
            pick = $urandom_range(0, 99);
            if (fill_left > 0) begin
                it.command = kot_pkg::CMD_PUT;
                fill_left--;
            end else if (pick < 50) begin
                it.command = kot_pkg::CMD_PUT;
            end else if (pick < 80) begin
                it.command = kot_pkg::CMD_TAKE;
            end else if (pick < 95) begin
                it.command = kot_pkg::CMD_REMOVE_ALL;
            end else begin
                it.command = CMD_UNUSED;
            end
            if ($urandom_range(0, 9) == 0) begin
                it.flight_key = {$urandom, $urandom};
            end else begin
                it.flight_key = pool_variant($urandom_range(0, POOL_SIZE - 1));
            end
            it.in_heading  = 16'($urandom);
            it.in_speed    = 16'($urandom);
            it.in_altitude = 16'($urandom);
            issue(it, 1'b0, '0);
            if ($urandom_range(1, 100) <= idle_pct) begin
                if ($urandom_range(0, 9) == 0) begin
                    hold_off($urandom_range(5, 70));
                end else begin
                    hold_off($urandom_range(1, 4));
                end
            end
        end
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
            failures++;
        end
    endtask

    // Each strobed result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        kot_pkg::t_result want;
        if (i_rst_n && o_result_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got %h", $time, o_result);
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(o_result.status));
                check_field("out_heading", want.out_heading, o_result.out_heading);
                check_field("out_speed", want.out_speed, o_result.out_speed);
                check_field("out_altitude", want.out_altitude, o_result.out_altitude);
                check_field("entry_count", 16'(want.entry_count),
                            16'(o_result.entry_count));
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_item     <= '0;
        held_count = 0;
        failures   = 0;

        // Directed rows: empty table, key extremes, keys that differ only past a zero
        // byte, swap on take, matches swapped in during remove-all, and the unused code.
        plan.push_back(row(kot_pkg::CMD_TAKE, 64'h41, 0, 0, 0, 1, kot_pkg::ST_NOMATCH,
                           0, 0, 0, 0));
        plan.push_back(row(kot_pkg::CMD_REMOVE_ALL, '1, 0, 0, 0, 1, kot_pkg::ST_NOMATCH,
                           0, 0, 0, 0));
        plan.push_back(row(CMD_UNUSED, '1, '1, '1, '1, 1, kot_pkg::ST_NOMATCH, 0, 0, 0, 0));
        plan.push_back(row(kot_pkg::CMD_PUT, '1, '1, '1, '1, 1, kot_pkg::ST_DONE,
                           0, 0, 0, 1));
        plan.push_back(row(kot_pkg::CMD_PUT, '0, 0, 0, 0, 1, kot_pkg::ST_DONE, 0, 0, 0, 2));
        plan.push_back(row(kot_pkg::CMD_PUT, 64'h4241, 1, 2, 3, 1, kot_pkg::ST_DONE,
                           0, 0, 0, 3));
        plan.push_back(row(kot_pkg::CMD_PUT, 64'hFFFF_FFFF_0000_4241, 4, 5, 6, 1,
                           kot_pkg::ST_DONE, 0, 0, 0, 4));
        plan.push_back(row(kot_pkg::CMD_PUT, 64'h8000_0000_0000_0000, 16'h1111, 16'h2222,
                           16'h3333, 1, kot_pkg::ST_DONE, 0, 0, 0, 5));
        plan.push_back(row(kot_pkg::CMD_PUT, 64'h0101_0101_0101_0101, 16'hAAAA, 16'h5555,
                           16'hAAAA, 1, kot_pkg::ST_DONE, 0, 0, 0, 6));
        plan.push_back(row(kot_pkg::CMD_TAKE, '1, 0, 0, 0, 1, kot_pkg::ST_DONE,
                           '1, '1, '1, 5));
        plan.push_back(row(kot_pkg::CMD_TAKE, 64'h0101_0101_0101_0101, 0, 0, 0, 1,
                           kot_pkg::ST_DONE, 16'hAAAA, 16'h5555, 16'hAAAA, 4));
        plan.push_back(row(kot_pkg::CMD_REMOVE_ALL, 64'hFF00, 0, 0, 0, 0, kot_pkg::ST_DONE,
                           0, 0, 0, 0));
        plan.push_back(row(kot_pkg::CMD_PUT, 64'h4241, 7, 8, 9, 0, kot_pkg::ST_DONE,
                           0, 0, 0, 0));
        plan.push_back(row(kot_pkg::CMD_REMOVE_ALL, 64'h1234_5678_0000_4241, 0, 0, 0, 0,
                           kot_pkg::ST_DONE, 0, 0, 0, 0));
        plan.push_back(row(kot_pkg::CMD_TAKE, 64'h4241, 0, 0, 0, 1, kot_pkg::ST_NOMATCH,
                           0, 0, 0, 0));
        plan.push_back(row(kot_pkg::CMD_PUT, 64'h4142_4344_4546_4748, 16'h0001, 16'h8000,
                           16'h7FFF, 1, kot_pkg::ST_DONE, 0, 0, 0, 1));
        plan.push_back(row(kot_pkg::CMD_PUT, 64'h0042_4344_4546_4748, '1, 0, '1, 1,
                           kot_pkg::ST_DONE, 0, 0, 0, 2));
        plan.push_back(row(kot_pkg::CMD_TAKE, 64'hFF42_4344_4546_4748, 0, 0, 0, 1,
                           kot_pkg::ST_NOMATCH, 0, 0, 0, 2));
        plan.push_back(row(kot_pkg::CMD_TAKE, 64'h0042_4344_4546_4748, 0, 0, 0, 1,
                           kot_pkg::ST_DONE, '1, 0, '1, 1));
        plan.push_back(row(CMD_UNUSED, 64'h4142_4344_4546_4748, 0, 0, 0, 1,
                           kot_pkg::ST_NOMATCH, 0, 0, 0, 1));
        plan.push_back(row(kot_pkg::CMD_TAKE, 64'h4142_4344_4546_4748, 0, 0, 0, 1,
                           kot_pkg::ST_DONE, 16'h0001, 16'h8000, 16'h7FFF, 0));
        plan.push_back(row(kot_pkg::CMD_REMOVE_ALL, '0, 0, 0, 0, 1, kot_pkg::ST_NOMATCH,
                           0, 0, 0, 0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            issue(plan[n].it, plan[n].typed, plan[n].want);
        end
        drain();

        // Random phases with different sender idling; each ends with a full drain.
        for (int ph = 0; ph < PHASES; ph++) begin
            refresh_pool();
            run_random(PHASE_LEN, IDLE_PCT[ph]);
            drain();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (failures == 0) begin
            $display("keyed_order_table_test OK");
        end else begin
            $display("keyed_order_table_test NOT OK");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/kot_pkg.sv
design/kot_ram.sv
design/kot_ctrl.sv
design/kot_dp.sv
design/keyed_order_table.sv
sim/keyed_order_table_test.sv
